FILE: hw/rtl/quoted_argument_tokenizer_core_macros.svh
// Assertion helpers used by the checker file.
`ifndef QUOTED_ARGUMENT_TOKENIZER_CORE_MACROS_SVH
`define QUOTED_ARGUMENT_TOKENIZER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define QATC_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("qatc check failed");

// Consequent must hold in the cycle after the antecedent.
`define QATC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("qatc check failed");

`endif

FILE: hw/rtl/qatc_pkg.sv
package qatc_pkg;

   localparam int MAX_TOKENS  = 16;
   localparam int TOKEN_CHARS = 256;
   localparam int CHAR_W      = $clog2(TOKEN_CHARS);
   localparam int TOK_W       = $clog2(MAX_TOKENS + 1);

   // Most words one input can cause, and the result queue that holds them.
   localparam int MAX_RESULTS = 3;
   localparam int FIFO_DEPTH  = 4;
   localparam int PTR_W       = $clog2(FIFO_DEPTH);
   localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);
   localparam int NCNT_W      = $clog2(MAX_RESULTS + 1);

   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = 32;
   localparam int RSP_USER_W  = 2;

   localparam logic [7:0] CHR_SQUOTE    = 8'h27;
   localparam logic [7:0] CHR_DQUOTE    = 8'h22;
   localparam logic [7:0] CHR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHR_SPACE     = 8'h20;
   localparam logic [7:0] CHR_TAB       = 8'h09;
   localparam logic [7:0] CHR_CR        = 8'h0D;

   typedef enum logic [1:0] {
      QUOTE_NONE,
      QUOTE_SINGLE,
      QUOTE_DOUBLE
   } quote_type;

   typedef enum logic [RSP_USER_W-1:0] {
      KIND_CHAR,
      KIND_END,
      KIND_FINISH
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  char_out;
      logic [3:0]  token_index;
      logic [7:0]  char_pos;
      logic [4:0]  token_total;
      logic        last;
   } rsp_word_type;

   function automatic logic is_ws(input logic [7:0] b);
      return (b == CHR_SPACE) || ((b >= CHR_TAB) && (b <= CHR_CR));
   endfunction

   function automatic quote_type quote_code(input logic [7:0] b);
      quote_type q;
      q = QUOTE_NONE;
      if (b == CHR_SQUOTE) q = QUOTE_SINGLE;
      else if (b == CHR_DQUOTE) q = QUOTE_DOUBLE;
      return q;
   endfunction

   function automatic rsp_word_type make_word(input kind_type         kind,
                                              input logic [7:0]       ch,
                                              input logic [TOK_W-1:0] idx,
                                              input logic [CHAR_W-1:0] pos,
                                              input logic [TOK_W-1:0] total);
      rsp_word_type w;
      w.kind        = kind;
      w.char_out    = ch;
      w.token_index = 4'(idx);
      w.char_pos    = 8'(pos);
      w.token_total = 5'(total);
      w.last        = 1'b0;
      return w;
   endfunction

endpackage

FILE: hw/rtl/quoted_argument_tokenizer_core.sv
// Shell-style argument splitter, one byte per input word.
// Input channel req_*: tdata carries a byte, tlast marks the end of the string
// (byte ignored); the end word flushes the open token and reports the count.
// Result channel rsp_*: tuser is the word kind (character, token ended, string
// finished), tlast marks the last result word caused by one input word.
// Each input word updates the tokenizer state in the cycle it is accepted and
// pushes zero to three result words into a four-entry result queue; the first
// of them is offered on rsp_* from the queue once the older words have left it.
// Throughput: one input word per cycle as long as the receiver takes every word
// and each byte yields at most one result word, since the queue drains one word per
// cycle. A word that yields two or three results (three: end of string with an open
// token and a pending backslash) holds the input until the queue has room again.
// req_tready is high while the queue has room for three words. When the receiver
// stalls, the queue fills and req_tready drops; nothing is lost. Reset clears
// quoting, escape, counters and the queue, so req_tready is high once it is released.
module quoted_argument_tokenizer_core
   import qatc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [7:0] byte_in
   input  logic                  req_tlast,   // is_end
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [7:0] char_out, [11:8] token_index,
                                              // [19:12] char_pos, [24:20] token_total
   output logic [RSP_USER_W-1:0] rsp_tuser,   // [1:0] kind
   output logic                  rsp_tlast    // last_of_run
);

   localparam logic [CHAR_W-1:0] CHAR_LAST = CHAR_W'(TOKEN_CHARS - 1);
   localparam logic [TOK_W-1:0]  TOK_LIMIT = TOK_W'(MAX_TOKENS);

   quote_type           quote_ff, quote_in;
   logic                in_token_ff, in_token_in;
   logic                escape_ff, escape_in;
   logic [TOK_W-1:0]    token_count_ff, token_count_in;
   logic [CHAR_W-1:0]   char_count_ff, char_count_in;

   rsp_word_type        mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   rsp_word_type        res [MAX_RESULTS];
   logic [NCNT_W-1:0]   nres;
   logic                accept, pop, plain;
   quote_type           qc;
   logic [7:0]          b;
   rsp_word_type        head;

   assign accept = req_tvalid && req_tready;
   assign pop    = rsp_tvalid && rsp_tready;
   assign b      = req_tdata[7:0];
   assign qc     = quote_code(b);

   always_comb begin
      quote_in       = quote_ff;
      in_token_in    = in_token_ff;
      escape_in      = escape_ff;
      token_count_in = token_count_ff;
      char_count_in  = char_count_ff;
      nres           = '0;
      plain          = 1'b0;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         res[i] = '0;
      end

      if (req_tlast) begin
         if (in_token_ff) begin
            // a backslash still waiting for its next byte is kept literally
            if (escape_ff && (char_count_in != CHAR_LAST)) begin
               res[nres] = make_word(KIND_CHAR, CHR_BACKSLASH, token_count_in,
                                     char_count_in, '0);
               nres = nres + NCNT_W'(1);
               char_count_in = char_count_in + CHAR_W'(1);
            end
            res[nres] = make_word(KIND_END, '0, token_count_in, char_count_in, '0);
            nres = nres + NCNT_W'(1);
            token_count_in = token_count_in + TOK_W'(1);
         end
         res[nres] = make_word(KIND_FINISH, '0, '0, '0, token_count_in);
         nres = nres + NCNT_W'(1);
         quote_in       = QUOTE_NONE;
         in_token_in    = 1'b0;
         escape_in      = 1'b0;
         token_count_in = '0;
         char_count_in  = '0;
      end else begin
         plain = 1'b1;
         if (escape_ff) begin
            escape_in = 1'b0;
            if ((b == CHR_BACKSLASH) || ((quote_ff != QUOTE_NONE) && (qc == quote_ff))) begin
               plain = 1'b0;
               if (char_count_in != CHAR_LAST) begin
                  res[nres] = make_word(KIND_CHAR, b, token_count_in, char_count_in, '0);
                  nres = nres + NCNT_W'(1);
                  char_count_in = char_count_in + CHAR_W'(1);
               end
            end else if (char_count_in != CHAR_LAST) begin
               res[nres] = make_word(KIND_CHAR, CHR_BACKSLASH, token_count_in,
                                     char_count_in, '0);
               nres = nres + NCNT_W'(1);
               char_count_in = char_count_in + CHAR_W'(1);
            end
         end

         if (plain) begin
            if (!in_token_in && !is_ws(b) && (token_count_in < TOK_LIMIT)) begin
               in_token_in   = 1'b1;
               char_count_in = '0;
               quote_in      = QUOTE_NONE;
            end
            if (in_token_in) begin
               if ((quote_in == QUOTE_NONE) && is_ws(b)) begin
                  res[nres] = make_word(KIND_END, '0, token_count_in, char_count_in, '0);
                  nres = nres + NCNT_W'(1);
                  token_count_in = token_count_in + TOK_W'(1);
                  in_token_in    = 1'b0;
                  quote_in       = QUOTE_NONE;
                  char_count_in  = '0;
               end else if ((qc != QUOTE_NONE) && (quote_in == QUOTE_NONE)) begin
                  quote_in = qc;
               end else if ((qc != QUOTE_NONE) && (quote_in == qc)) begin
                  quote_in = QUOTE_NONE;
               end else if (b == CHR_BACKSLASH) begin
                  escape_in = 1'b1;
               end else if (char_count_in != CHAR_LAST) begin
                  res[nres] = make_word(KIND_CHAR, b, token_count_in, char_count_in, '0);
                  nres = nres + NCNT_W'(1);
                  char_count_in = char_count_in + CHAR_W'(1);
               end
            end
         end
      end

      // flag the final word of this input
      for (int i = 0; i < MAX_RESULTS; i++) begin
         res[i].last = (NCNT_W'(i) == nres - NCNT_W'(1));
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (accept) begin
         wr_ptr_in = wr_ptr_ff + PTR_W'(nres);
         count_in  = count_in + CNT_W'(nres);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + PTR_W'(1);
         count_in  = count_in - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quote_ff       <= QUOTE_NONE;
         in_token_ff    <= 1'b0;
         escape_ff      <= 1'b0;
         token_count_ff <= '0;
         char_count_ff  <= '0;
         wr_ptr_ff      <= '0;
         rd_ptr_ff      <= '0;
         count_ff       <= '0;
      end else begin
         if (accept) begin
            quote_ff       <= quote_in;
            in_token_ff    <= in_token_in;
            escape_ff      <= escape_in;
            token_count_ff <= token_count_in;
            char_count_ff  <= char_count_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < MAX_RESULTS; i++) begin
            if (NCNT_W'(i) < nres) begin
               mem_ff[wr_ptr_ff + PTR_W'(i)] <= res[i];
            end
         end
      end
   end

   assign req_tready = (count_ff <= CNT_W'(FIFO_DEPTH - MAX_RESULTS));
   assign rsp_tvalid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];
   assign rsp_tuser  = head.kind;
   assign rsp_tlast  = head.last;
   assign rsp_tdata  = RSP_DATA_W'({head.token_total, head.char_pos,
                                    head.token_index, head.char_out});

endmodule

FILE: hw/rtl/qatc_checker.sv
`include "quoted_argument_tokenizer_core_macros.svh"

module qatc_checker
   import qatc_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [RSP_USER_W-1:0] rsp_tuser,
   input logic                  rsp_tlast
);

   logic rsp_stall;
   logic finish_word;

   assign rsp_stall   = rsp_tvalid && !rsp_tready;
   assign finish_word = rsp_tvalid && (rsp_tuser == KIND_FINISH);

   // hold the word while the receiver stalls
   `QATC_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_tvalid && $stable({rsp_tdata, rsp_tuser, rsp_tlast}))

   // finish word always closes the run of its end marker
   `QATC_ASSERT_SAME(a_finish_last, finish_word, rsp_tlast)

   // finish word carries only the count
   `QATC_ASSERT_SAME(a_finish_clean, finish_word, rsp_tdata[19:0] == '0)

   // character and token-end words carry no count
   `QATC_ASSERT_SAME(a_count_only_finish, rsp_tvalid && !finish_word, rsp_tdata[24:20] == '0)

endmodule

bind quoted_argument_tokenizer_core qatc_checker u_qatc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

FILE: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import qatc_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   typedef struct packed {
      logic [7:0] byte_val;
      logic       end_mark;
   } arg_item_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  rsp_tlast;

   // input bytes waiting to be sent, and result words still due from the block
   arg_item_type arg_bytes[$];
   rsp_word_type words_due[$];
   rsp_word_type run_words[$];

   int queued_cnt = 0;
   int accepted_cnt = 0;
   int fail_cnt = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int cycle_cnt = 0;

   // tokenizer state as the block should hold it
   quote_type  tk_quote = QUOTE_NONE;
   bit         tk_in_token = 1'b0;
   bit         tk_escape = 1'b0;
   logic [4:0] tk_tokens = '0;
   logic [7:0] tk_chars = '0;

   arg_item_type drv_item;
   rsp_word_type mon_word;

   quoted_argument_tokenizer_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   function automatic bit is_blank(logic [7:0] b);
      return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
   endfunction

   function automatic quote_type quote_of(logic [7:0] b);
      if (b == CHR_SQUOTE) return QUOTE_SINGLE;
      if (b == CHR_DQUOTE) return QUOTE_DOUBLE;
      return QUOTE_NONE;
   endfunction

   task automatic push_word(kind_type k, logic [7:0] ch, logic [3:0] idx, logic [7:0] pos,
                            logic [4:0] total);
      rsp_word_type w;
      w.kind        = k;
      w.char_out    = ch;
      w.token_index = idx;
      w.char_pos    = pos;
      w.token_total = total;
      w.last        = 1'b0;
      run_words.push_back(w);
   endtask

   // drop the character once the token holds TOKEN_CHARS-1
   task automatic keep_char(logic [7:0] c);
      if (({1'b0, tk_chars} + 9'd1) < TOKEN_CHARS) begin
         push_word(KIND_CHAR, c, tk_tokens[3:0], tk_chars, 5'd0);
         tk_chars++;
      end
   endtask

   task automatic close_token();
      push_word(KIND_END, 8'h00, tk_tokens[3:0], tk_chars, 5'd0);
      tk_tokens++;
      tk_in_token = 1'b0;
      tk_quote    = QUOTE_NONE;
      tk_chars    = '0;
   endtask

   task automatic plain_byte(logic [7:0] b);
      quote_type q;
      q = quote_of(b);
      if (!tk_in_token && !is_blank(b) && (tk_tokens < MAX_TOKENS)) begin
         tk_in_token = 1'b1;
         tk_chars    = '0;
         tk_quote    = QUOTE_NONE;
      end
      if (tk_in_token) begin
         if (tk_quote == QUOTE_NONE && is_blank(b)) begin
            close_token();
         end else if (q != QUOTE_NONE && tk_quote == QUOTE_NONE) begin
            tk_quote = q;
         end else if (q != QUOTE_NONE && tk_quote == q) begin
            tk_quote = QUOTE_NONE;
         end else if (b == CHR_BACKSLASH) begin
            tk_escape = 1'b1;
         end else begin
            keep_char(b);
         end
      end
   endtask

   task automatic tokenize_byte(logic [7:0] b, logic end_mark);
      rsp_word_type w;
      run_words.delete();
      if (end_mark) begin
         if (tk_in_token) begin
            if (tk_escape) keep_char(CHR_BACKSLASH);
            close_token();
         end
         push_word(KIND_FINISH, 8'h00, 4'd0, 8'd0, tk_tokens);
         tk_quote    = QUOTE_NONE;
         tk_in_token = 1'b0;
         tk_escape   = 1'b0;
         tk_tokens   = '0;
         tk_chars    = '0;
      end else if (tk_escape) begin
         tk_escape = 1'b0;
         if (b == CHR_BACKSLASH || (tk_quote != QUOTE_NONE && quote_of(b) == tk_quote)) begin
            keep_char(b);
         end else begin
            keep_char(CHR_BACKSLASH);
            plain_byte(b);
         end
      end else begin
         plain_byte(b);
      end
      if (run_words.size() != 0) begin
         w = run_words.pop_back();
         w.last = 1'b1;
         run_words.push_back(w);
      end
      foreach (run_words[i]) words_due.push_back(run_words[i]);
   endtask

   task automatic check_field(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
         $error("%s: expected %0d, got %0d", name, exp_val, act_val);
         fail_cnt++;
      end
   endtask

   // stimulus builders
   task automatic add_byte(logic [7:0] b);
      arg_item_type it;
      it.byte_val = b;
      it.end_mark = 1'b0;
      arg_bytes.push_back(it);
      queued_cnt++;
   endtask

   task automatic add_end();
      arg_item_type it;
      it.byte_val = 8'($urandom_range(0, 255));
      it.end_mark = 1'b1;
      arg_bytes.push_back(it);
      queued_cnt++;
   endtask

   task automatic add_text(string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endtask

   function automatic logic [7:0] rand_letter();
      return 8'($urandom_range(8'h61, 8'h7A));
   endfunction

   function automatic logic [7:0] rand_blank();
      int k;
      k = $urandom_range(0, 5);
      return (k == 0) ? CHR_SPACE : 8'(8 + k);
   endfunction

   function automatic logic [7:0] rand_mixed();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return rand_letter();
      if (r < 55) return rand_blank();
      if (r < 65) return CHR_SQUOTE;
      if (r < 75) return CHR_DQUOTE;
      if (r < 85) return CHR_BACKSLASH;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic add_quoted();
      logic [7:0] qc;
      logic [7:0] other;
      int n;
      qc    = $urandom_range(0, 1) ? CHR_SQUOTE : CHR_DQUOTE;
      other = (qc == CHR_SQUOTE) ? CHR_DQUOTE : CHR_SQUOTE;
      n     = $urandom_range(0, 6);
      add_byte(qc);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 9))
            6: add_byte(rand_blank());
            7: add_byte(other);
            8: begin
               add_byte(CHR_BACKSLASH);
               add_byte($urandom_range(0, 1) ? qc : CHR_BACKSLASH);
            end
            9: begin
               add_byte(CHR_BACKSLASH);
               add_byte(rand_letter());
            end
            default: add_byte(rand_letter());
         endcase
      end
      add_byte(qc);
   endtask

   task automatic add_argument();
      int segs;
      segs = $urandom_range(1, 3);
      for (int s = 0; s < segs; s++) begin
         if ($urandom_range(0, 2) == 0) begin
            add_quoted();
         end else begin
            for (int i = $urandom_range(1, 4); i > 0; i--) begin
               if ($urandom_range(0, 7) == 0) add_byte(CHR_BACKSLASH);
               add_byte(rand_letter());
            end
         end
      end
   endtask

   task automatic add_command();
      int ntok;
      ntok = $urandom_range(0, 4);
      if ($urandom_range(0, 3) == 0) add_byte(rand_blank());
      for (int t = 0; t < ntok; t++) begin
         add_argument();
         if (t < ntok - 1 || $urandom_range(0, 1)) begin
            for (int i = $urandom_range(1, 2); i > 0; i--) add_byte(rand_blank());
         end
      end
      add_end();
   endtask

   // noise may end without an end marker: the next command then starts from whatever state is left
   task automatic add_noise();
      for (int i = $urandom_range(1, 8); i > 0; i--) begin
         if ($urandom_range(0, 7) == 0) add_end();
         else add_byte(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic add_random(int n);
      int start;
      start = queued_cnt;
      while (queued_cnt - start < n) begin
         case ($urandom_range(0, 9))
            7, 8: begin
               for (int i = $urandom_range(0, 10); i > 0; i--) add_byte(rand_mixed());
               add_end();
            end
            9: add_noise();
            default: add_command();
         endcase
      end
   endtask

   task automatic drain();
      while (accepted_cnt != queued_cnt || words_due.size() != 0) @(posedge clock);
   endtask

   // input driver and model update at acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            tokenize_byte(req_tdata, req_tlast);
            accepted_cnt++;
         end
         if (!req_tvalid || req_tready) begin
            if (arg_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               drv_item = arg_bytes.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= drv_item.byte_val;
               req_tlast  <= drv_item.end_mark;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (words_due.size() == 0) begin
            $error("unexpected result word: tuser %0d tdata %h", rsp_tuser, rsp_tdata);
            fail_cnt++;
         end else begin
            mon_word = words_due.pop_front();
            check_field("kind", mon_word.kind, rsp_tuser);
            check_field("char_out", mon_word.char_out, rsp_tdata[7:0]);
            check_field("token_index", mon_word.token_index, rsp_tdata[11:8]);
            check_field("char_pos", mon_word.char_pos, rsp_tdata[19:12]);
            check_field("token_total", mon_word.token_total, rsp_tdata[24:20]);
            check_field("last_of_run", mon_word.last, rsp_tlast);
         end
      end
      rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   initial begin
      while (cycle_cnt < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_cnt++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: empty string, empty quotes, blanks and the other quote inside quotes,
      // escapes, zero and all-ones bytes, backslash at end, unclosed quote at end
      add_end();
      add_text("'' ");
      add_text("\"a '\"");
      add_text("\\\\\\\"");
      add_byte(8'h00);
      add_byte(8'hFF);
      add_text("\\");
      add_end();
      add_text("b\t\"\\\"\\");
      add_end();
      add_random(25);
      drain();

      send_idle_pct = 62;
      add_random(25);
      // one token long enough to saturate the character count
      for (int i = 0; i < 260; i++) add_byte(rand_letter());
      add_byte(rand_blank());
      add_end();
      drain();

      send_idle_pct  = 0;
      recv_stall_pct = 62;
      add_random(25);
      // run past the token limit, then bytes that must be ignored
      for (int i = 0; i < 18; i++) begin
         add_byte(rand_letter());
         add_byte(rand_blank());
      end
      add_quoted();
      add_end();
      drain();

      send_idle_pct  = 24;
      recv_stall_pct = 24;
      add_random(25);
      drain();

      repeat (20) @(posedge clock);
      if (words_due.size() != 0) begin
         $error("%0d result words never arrived", words_due.size());
         fail_cnt++;
      end
      if (fail_cnt == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/qatc_pkg.sv
hw/rtl/quoted_argument_tokenizer_core.sv
hw/rtl/qatc_checker.sv
dv/testbench.sv
